### rtl/fbpr_pkg.sv
// Shared types and constants for the frame buffer partial refresh block.
package fbpr_pkg;
	typedef enum logic [2:0] {
		OP_DRAW  = 3'd0,
		OP_FILL  = 3'd1,
		OP_READ  = 3'd2,
		OP_REFR  = 3'd3,
		OP_SEND  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		RK_DONE   = 2'd0,
		RK_DATA   = 2'd1,
		RK_SAME   = 2'd2,
		RK_READ   = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		CFG_COL = 1'b0,
		CFG_ROW = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_READ_WAIT,
		ST_READ_DATA,
		ST_SUM_RD,
		ST_SUM_DONE,
		ST_SEND_RD,
		ST_SEND_GRP,
		ST_OUT
	} state_t;

	localparam int unsigned CRC_MUL  = 31;
	localparam int unsigned ROT_LEFT = 7;
	localparam int unsigned ROT_RIGHT = 9;
	localparam int unsigned MAX_GROUPS = 32;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  prow;
		logic [7:0]  col;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [9:0]  x_first;
		logic [9:0]  x_second;
		logic [9:0]  y_first;
		logic [9:0]  y_second;
		logic [15:0] color;
		logic        xor_mode;
		logic [6:0]  row_select;
	} request_t;

	function automatic logic [31:0] sum_step(input logic [31:0] c, input logic [15:0] p);
		logic [31:0] t;
		t = ((c << ROT_LEFT) | (c >> ROT_RIGHT)) ^ {16'd0, p};
		return t + {16'd0, p} * 32'(CRC_MUL);
	endfunction
endpackage

### rtl/fbpr_if.sv
// Valid/ready channel interfaces for request and result.
interface fbpr_req_if;
	logic                 valid;
	logic                 ready;
	fbpr_pkg::request_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fbpr_res_if;
	logic                 valid;
	logic                 ready;
	fbpr_pkg::result_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/framebuffer_partial_refresh.sv
// Frame store with per-row checksum partial refresh: after reset a clearing pass writes every
// pixel and checksum to zero, with no request taken. All work runs one frame store access per
// cycle through a single memory port and one checksum step unit. A draw or read passes through
// ST_READ_WAIT and ST_READ_DATA before its result is registered; a fill reads and then writes
// each covered pixel (ST_FILL_RD, ST_FILL_WR) and goes straight to its result if it covers none;
// a refresh reads and sums the row; a send, or a refresh of a changed row, reads the pixels of
// each result group in ST_SEND_RD and forms the result in ST_SEND_GRP. Each result waits in an
// output register until taken, and the next request is taken in the cycle after the final
// result leaves.
module framebuffer_partial_refresh #(
	parameter int unsigned SCREEN_WIDTH = 128,
	parameter int unsigned SCREEN_HEIGHT = 128,
	parameter int unsigned PIXELS_PER_RESULT = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	fbpr_req_if.sink      req,
	fbpr_res_if.source    res,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data
);
	localparam int unsigned XW = $clog2(SCREEN_WIDTH);
	localparam int unsigned YW = $clog2(SCREEN_HEIGHT);
	localparam int unsigned AW = XW + YW;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned GCNT = (SCREEN_WIDTH + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
	localparam int unsigned NGRP = GCNT < fbpr_pkg::MAX_GROUPS ? GCNT : fbpr_pkg::MAX_GROUPS;
	localparam int unsigned CW = XW + 1;
	localparam logic signed [9:0] XMAX = 10'(SCREEN_WIDTH - 1);
	localparam logic signed [9:0] YMAX = 10'(SCREEN_HEIGHT - 1);

	fbpr_pkg::state_t state_q, state_d;
	logic [7:0] col_off_q, row_off_q;
	fbpr_pkg::request_t r_q;
	logic signed [9:0] xs_q, xe_q, ys_q, ye_q;
	logic [CW-1:0] x_q;
	logic [YW:0]  y_q;
	logic [AW-1:0] clr_q;
	logic [31:0]  sum_q;
	logic [2:0]   k_q;
	logic [15:0]  px_q [4];
	logic [CW-1:0] gcol_q;
	logic [5:0]   grp_q;
	logic         rd_valid_q;
	logic         res_valid_q;
	fbpr_pkg::result_t res_q, res_d;
	logic         res_load;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata, mem_rdata;
	logic          cs_we;
	logic [YW-1:0] cs_addr;
	logic [15:0]   cs_wdata, cs_rdata;

	fbpr_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata));
	fbpr_csum_mem #(.DEPTH(1 << YW), .AW(YW)) u_csum (
		.clk(clk), .we(cs_we), .addr(cs_addr), .wdata(cs_wdata), .rdata(cs_rdata));

	logic signed [9:0] rx0, ry0;
	logic signed [9:0] in_x0, in_x1, in_y0, in_y1, x_lo, x_hi, y_lo, y_hi;
	logic pix_on;
	logic row_ok;
	logic [7:0] prow;
	assign rx0 = $signed(r_q.x_first);
	assign ry0 = $signed(r_q.y_first);
	assign pix_on = (rx0 >= 0) && (ry0 >= 0) && (rx0 < $signed(10'(SCREEN_WIDTH)))
		&& (ry0 < $signed(10'(SCREEN_HEIGHT)));
	assign row_ok = 32'(r_q.row_select) < SCREEN_HEIGHT;
	assign prow = 8'(r_q.row_select) + row_off_q;

	assign in_x0 = $signed(req.payload.x_first);
	assign in_x1 = $signed(req.payload.x_second);
	assign in_y0 = $signed(req.payload.y_first);
	assign in_y1 = $signed(req.payload.y_second);
	assign x_lo = (in_x0 < in_x1) ? in_x0 : in_x1;
	assign x_hi = (in_x0 < in_x1) ? in_x1 : in_x0;
	assign y_lo = (in_y0 < in_y1) ? in_y0 : in_y1;
	assign y_hi = (in_y0 < in_y1) ? in_y1 : in_y0;

	logic accept;
	assign req.ready = (state_q == fbpr_pkg::ST_IDLE);
	assign accept = req.valid && req.ready;
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	logic last_x, last_y, fill_empty, last_pix_in_grp, row_end, last_grp, sum_same;
	assign last_x = x_q == CW'(xe_q);
	assign last_y = y_q == (YW+1)'(ye_q);
	assign fill_empty = (xs_q > xe_q) || (ys_q > ye_q);
	assign row_end = x_q == CW'(SCREEN_WIDTH - 1);
	assign last_pix_in_grp = (k_q == 3'(PIXELS_PER_RESULT - 1)) || row_end;
	assign last_grp = (grp_q == 6'(NGRP - 1));
	assign sum_same = cs_rdata == sum_q[15:0];

	logic [AW-1:0] pix_addr, row_addr;
	assign pix_addr = {YW'(r_q.y_first), XW'(r_q.x_first)};
	assign row_addr = {YW'(r_q.row_select), XW'(x_q)};

	// Group slots: the last pixel read comes straight from the memory.
	logic [15:0] grp_px [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) == k_q - 3'd1) grp_px[i] = mem_rdata;
			else if (3'(i) < k_q) grp_px[i] = px_q[i];
			else grp_px[i] = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbpr_pkg::ST_CLEAR:
				if (clr_q == '1) state_d = fbpr_pkg::ST_IDLE;
			fbpr_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.payload.operation) inside
						fbpr_pkg::OP_DRAW, fbpr_pkg::OP_READ:
							state_d = fbpr_pkg::ST_READ_WAIT;
						fbpr_pkg::OP_FILL: state_d = fbpr_pkg::ST_FILL_RD;
						fbpr_pkg::OP_REFR: state_d = fbpr_pkg::ST_SUM_RD;
						fbpr_pkg::OP_SEND: state_d = fbpr_pkg::ST_SEND_RD;
						default:           state_d = fbpr_pkg::ST_IDLE;
					endcase
				end
			end
			fbpr_pkg::ST_READ_WAIT: state_d = fbpr_pkg::ST_READ_DATA;
			fbpr_pkg::ST_READ_DATA: state_d = fbpr_pkg::ST_OUT;
			fbpr_pkg::ST_FILL_RD: begin
				if (fill_empty) state_d = fbpr_pkg::ST_OUT;
				else state_d = fbpr_pkg::ST_FILL_WR;
			end
			fbpr_pkg::ST_FILL_WR: begin
				if (last_x && last_y) state_d = fbpr_pkg::ST_OUT;
				else state_d = fbpr_pkg::ST_FILL_RD;
			end
			fbpr_pkg::ST_SUM_RD: begin
				if (!row_ok) state_d = fbpr_pkg::ST_OUT;
				else if (x_q == CW'(SCREEN_WIDTH)) state_d = fbpr_pkg::ST_SUM_DONE;
			end
			fbpr_pkg::ST_SUM_DONE: begin
				if (sum_same) state_d = fbpr_pkg::ST_OUT;
				else state_d = fbpr_pkg::ST_SEND_RD;
			end
			fbpr_pkg::ST_SEND_RD: begin
				if (!row_ok) state_d = fbpr_pkg::ST_OUT;
				else if (last_pix_in_grp) state_d = fbpr_pkg::ST_SEND_GRP;
			end
			fbpr_pkg::ST_SEND_GRP: state_d = fbpr_pkg::ST_OUT;
			fbpr_pkg::ST_OUT: begin
				if (res.ready) begin
					if (res_q.kind == fbpr_pkg::RK_DATA && !res_q.last)
						state_d = fbpr_pkg::ST_SEND_RD;
					else state_d = fbpr_pkg::ST_IDLE;
				end
			end
			default: state_d = fbpr_pkg::ST_IDLE;
		endcase
	end

	// Memory port, checksum store and result loading.
	always_comb begin
		mem_we = 1'b0;
		mem_addr = {YW'(y_q), XW'(x_q)};
		mem_wdata = r_q.color;
		cs_we = 1'b0;
		cs_addr = YW'(r_q.row_select);
		cs_wdata = sum_q[15:0];
		res_load = 1'b0;
		res_d = '0;
		res_d.kind = fbpr_pkg::RK_DONE;
		res_d.last = 1'b1;
		unique case (state_q)
			fbpr_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
				mem_wdata = '0;
				cs_we = 1'b1;
				cs_addr = YW'(clr_q);
				cs_wdata = '0;
			end
			fbpr_pkg::ST_READ_WAIT: begin
				mem_addr = pix_addr;
				mem_we = pix_on && (r_q.operation == fbpr_pkg::OP_DRAW);
			end
			fbpr_pkg::ST_READ_DATA: begin
				res_load = 1'b1;
				if (r_q.operation == fbpr_pkg::OP_READ) begin
					res_d.kind = fbpr_pkg::RK_READ;
					res_d.a = pix_on ? mem_rdata : '0;
				end
			end
			fbpr_pkg::ST_FILL_RD:
				res_load = fill_empty;
			fbpr_pkg::ST_FILL_WR: begin
				mem_we = 1'b1;
				mem_wdata = (r_q.xor_mode && mem_rdata != '0) ? ~r_q.color : r_q.color;
				res_load = last_x && last_y;
			end
			fbpr_pkg::ST_SUM_RD, fbpr_pkg::ST_SEND_RD: begin
				mem_addr = row_addr;
				if (!row_ok) begin
					res_load = 1'b1;
					res_d.kind = fbpr_pkg::RK_SAME;
					res_d.prow = prow;
				end
			end
			fbpr_pkg::ST_SUM_DONE: begin
				if (sum_same) begin
					res_load = 1'b1;
					res_d.kind = fbpr_pkg::RK_SAME;
					res_d.prow = prow;
				end else cs_we = 1'b1;
			end
			fbpr_pkg::ST_SEND_GRP: begin
				res_load = 1'b1;
				res_d.kind = fbpr_pkg::RK_DATA;
				res_d.prow = prow;
				res_d.col = 8'(gcol_q) + col_off_q;
				res_d.a = grp_px[0];
				res_d.b = grp_px[1];
				res_d.c = grp_px[2];
				res_d.d = grp_px[3];
				res_d.last = last_grp || (x_q == CW'(SCREEN_WIDTH));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbpr_pkg::ST_CLEAR;
			clr_q <= '0;
			col_off_q <= '0;
			row_off_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fbpr_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				if (cfg_index == fbpr_pkg::CFG_COL) col_off_q <= cfg_data;
				else row_off_q <= cfg_data;
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_valid_q <= (state_q == fbpr_pkg::ST_SUM_RD) && (x_q != CW'(SCREEN_WIDTH));
		if (res_load) res_q <= res_d;
		unique case (state_q)
			fbpr_pkg::ST_IDLE: begin
				if (accept) begin
					r_q <= req.payload;
					grp_q <= '0;
					k_q <= '0;
					gcol_q <= '0;
					sum_q <= '0;
					for (int i = 0; i < 4; i++) px_q[i] <= '0;
					xs_q <= x_lo < 0 ? 10'sd0 : x_lo;
					xe_q <= x_hi > XMAX ? XMAX : x_hi;
					ys_q <= y_lo < 0 ? 10'sd0 : y_lo;
					ye_q <= y_hi > YMAX ? YMAX : y_hi;
					y_q <= y_lo < 0 ? '0 : (YW+1)'(y_lo);
					if (req.payload.operation == fbpr_pkg::OP_FILL && x_lo > 0)
						x_q <= CW'(x_lo);
					else x_q <= '0;
				end
			end
			fbpr_pkg::ST_FILL_WR: begin
				if (last_x) begin
					x_q <= CW'(xs_q);
					y_q <= y_q + 1'b1;
				end else x_q <= x_q + 1'b1;
			end
			fbpr_pkg::ST_SUM_RD: begin
				if (x_q != CW'(SCREEN_WIDTH)) x_q <= x_q + 1'b1;
				if (rd_valid_q) sum_q <= fbpr_pkg::sum_step(sum_q, mem_rdata);
			end
			fbpr_pkg::ST_SUM_DONE: begin
				x_q <= '0;
				gcol_q <= '0;
			end
			fbpr_pkg::ST_SEND_RD: begin
				x_q <= x_q + 1'b1;
				k_q <= k_q + 1'b1;
				// Capture the pixel read in the previous send cycle.
				if (k_q != '0) px_q[2'(k_q - 3'd1)] <= mem_rdata;
			end
			fbpr_pkg::ST_OUT: begin
				if (res.ready) begin
					for (int i = 0; i < 4; i++) px_q[i] <= '0;
					k_q <= '0;
					grp_q <= grp_q + 1'b1;
					gcol_q <= x_q;
				end
			end
			default: ;
		endcase
	end
endmodule

### rtl/fbpr_mem.sv
// Single-port frame store with registered read data.
module fbpr_mem #(
	parameter int unsigned DEPTH = 16384,
	parameter int unsigned AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/fbpr_csum_mem.sv
// Row checksum store with registered read data.
module fbpr_csum_mem #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/fbpr_checker.sv
// Port-level assertions for the frame buffer partial refresh block.
module fbpr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input fbpr_pkg::result_t    res_payload
);
	a_no_req_while_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready) else $error("request taken while result pending");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("result dropped or changed");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.kind != fbpr_pkg::RK_DATA |-> res_payload.last)
		else $error("non-data result without last");
	a_no_res_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !res_valid) else $error("result right after request");
endmodule

bind framebuffer_partial_refresh fbpr_checker u_fbpr_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_payload(res.payload));
